// File: sv/rsch_pkg.sv
// ----------------------------------------------------------------------------
// rsch_pkg: shared constants for the ray / sphere closest-hit block
// widths of the shared arithmetic units and of the stream payloads
// ----------------------------------------------------------------------------
package rsch_pkg;

  localparam int MAX_SPHERES_DEF = 16;

  // multiplier: signed 64 x 64 operands, 128-bit product
  localparam int MUL_W  = 64;
  localparam int PROD_W = 2 * MUL_W;

  // square root: 128-bit radicand, 64-bit root
  localparam int SQRT_IN_W  = PROD_W;
  localparam int SQRT_OUT_W = SQRT_IN_W / 2;

  // divider: 80-bit dividend, 64-bit divisor
  localparam int DIV_N_W = 80;
  localparam int DIV_D_W = 64;

  // stream payloads, padded to whole bytes
  localparam int S_TDATA_W = 336;
  localparam int M_TDATA_W = 216;

endpackage

// File: sv/rsch_mul.sv
// ----------------------------------------------------------------------------
// rsch_mul: shared signed multiplier
// 64 x 64 signed product from four 32 x 32 partial products, one per cycle
// ----------------------------------------------------------------------------
module rsch_mul (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [rsch_pkg::MUL_W-1:0]  a,
  input  logic signed [rsch_pkg::MUL_W-1:0]  b,
  output logic                             done,
  output logic        [rsch_pkg::PROD_W-1:0] p
);
  import rsch_pkg::*;

  localparam int HW = MUL_W / 2;

  logic              busy;
  logic [2:0]        cnt;
  logic [MUL_W-1:0]  ma;
  logic [MUL_W-1:0]  mb;
  logic              neg;
  logic [MUL_W-1:0]  pp;
  logic [1:0]        psh;
  logic [PROD_W-1:0] acc;
  logic [HW-1:0]     opa;
  logic [HW-1:0]     opb;
  logic [PROD_W-1:0] pp_ext;

  assign opa    = cnt[1] ? ma[MUL_W-1:HW] : ma[HW-1:0];
  assign opb    = cnt[0] ? mb[MUL_W-1:HW] : mb[HW-1:0];
  assign pp_ext = {{(PROD_W-MUL_W){1'b0}}, pp} << (HW * int'(psh));

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      ma   <= a[MUL_W-1] ? MUL_W'(-a) : MUL_W'(a);
      mb   <= b[MUL_W-1] ? MUL_W'(-b) : MUL_W'(b);
      neg  <= a[MUL_W-1] ^ b[MUL_W-1];
      acc  <= '0;
    end else if (busy) begin
      cnt <= cnt + 3'd1;
      // partial product issue
      if (cnt <= 3'd3) begin
        pp  <= MUL_W'(opa) * MUL_W'(opb);
        psh <= 2'(cnt[1]) + 2'(cnt[0]);
      end
      // accumulate the previous partial product
      if (cnt >= 3'd1 && cnt <= 3'd4) begin
        acc <= acc + pp_ext;
      end
      if (cnt == 3'd5) begin
        p    <= neg ? PROD_W'(-acc) : acc;
        done <= 1'b1;
        busy <= 1'b0;
      end
    end
  end

endmodule

// File: sv/rsch_sqrt.sv
// ----------------------------------------------------------------------------
// rsch_sqrt: iterative integer square root
// restoring digit recurrence, one root bit per cycle, floor result
// ----------------------------------------------------------------------------
module rsch_sqrt (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [rsch_pkg::SQRT_IN_W-1:0]      x,
  output logic                                done,
  output logic [rsch_pkg::SQRT_OUT_W-1:0]     root
);
  import rsch_pkg::*;

  localparam int CW = $clog2(SQRT_OUT_W);
  localparam int RW = SQRT_OUT_W + 2;

  logic                 busy;
  logic [CW-1:0]        cnt;
  logic [SQRT_IN_W-1:0] rad;
  logic [RW-1:0]        rem;
  logic [RW+1:0]        rem2;
  logic [RW+1:0]        trial;
  logic                 take;

  assign rem2  = {rem, rad[SQRT_IN_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};
  assign take  = rem2 >= trial;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      rad  <= x;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= rad << 2;
      rem  <= take ? RW'(rem2 - trial) : RW'(rem2);
      root <= {root[SQRT_OUT_W-2:0], take};
      cnt  <= cnt + 1'b1;
      if (cnt == CW'(SQRT_OUT_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// File: sv/rsch_div.sv
// ----------------------------------------------------------------------------
// rsch_div: iterative unsigned divider
// restoring division, one quotient bit per cycle, truncated quotient
// ----------------------------------------------------------------------------
module rsch_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [rsch_pkg::DIV_N_W-1:0]   num,
  input  logic [rsch_pkg::DIV_D_W-1:0]   den,
  output logic                           done,
  output logic [rsch_pkg::DIV_N_W-1:0]   quo
);
  import rsch_pkg::*;

  localparam int CW = $clog2(DIV_N_W);

  logic               busy;
  logic [CW-1:0]      cnt;
  logic [DIV_N_W-1:0] dvd;
  logic [DIV_D_W-1:0] dvs;
  logic [DIV_D_W-1:0] rem;
  logic [DIV_D_W:0]   rem2;
  logic               take;

  assign rem2 = {rem, dvd[DIV_N_W-1]};
  assign take = rem2 >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      dvd  <= num;
      dvs  <= den;
      rem  <= '0;
      quo  <= '0;
    end else if (busy) begin
      dvd <= dvd << 1;
      rem <= take ? DIV_D_W'(rem2 - {1'b0, dvs}) : DIV_D_W'(rem2);
      quo <= {quo[DIV_N_W-2:0], take};
      cnt <= cnt + 1'b1;
      if (cnt == CW'(DIV_N_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// File: sv/ray_sphere_closest_hit.sv
// ----------------------------------------------------------------------------
// ray_sphere_closest_hit: closest ray / sphere intersection over a sphere table
// loads sphere entries, traces rays against the entries in use, reports hit
// ----------------------------------------------------------------------------
//
//  channel   direction  payload
//  s_*       in         tuser: cmd; tdata: load entry or ray with t window
//  m_*       out        tuser: hit; tdata: t, index, point, normal, face, albedo
//  apb       in/out     sphere_count register at byte address 0
//
//  a load is written to the table without leaving idle; a trace scans the
//  entries in use and, on a hit, computes the hit point and normal; per
//  entry the time goes to the shared multiplier (11 products), the 64-step
//  square root and one or two 80-step divisions
//  s_tready is high only while the sequencer is idle; a finished result waits
//  in the output register for m_tready; the next result then waits in S_OUT,
//  holding s_tready low; rst is synchronous; the sphere table is not cleared
//
module ray_sphere_closest_hit #(
  parameter int MAX_SPHERES = rsch_pkg::MAX_SPHERES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // input stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // tdata from bit 0: entry_index, origin_x, origin_y, origin_z, dir_x, dir_y,
  // dir_z, radius_squared, albedo_rgb, t_min, t_max, zero fill
  input  logic [rsch_pkg::S_TDATA_W-1:0]   s_tdata,
  // tuser: cmd
  input  logic [0:0]                       s_tuser,
  // result stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // tdata from bit 0: hit_t, hit_index, point_x, point_y, point_z, normal_x,
  // normal_y, normal_z, front_face, hit_albedo, zero fill
  output logic [rsch_pkg::M_TDATA_W-1:0]   m_tdata,
  // tuser: hit
  output logic [0:0]                       m_tuser,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import rsch_pkg::*;

  localparam int IW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int KW = $clog2(MAX_SPHERES + 1);
  localparam logic [DIV_N_W-1:0] ROOT_LIMIT = DIV_N_W'(1) << 40;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_TRACE = 1'b1;

  typedef struct packed {
    logic [23:0]        alb;
    logic [47:0]        rs;
    logic signed [31:0] cz;
    logic signed [31:0] cy;
    logic signed [31:0] cx;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_OC, S_MUL, S_MULW, S_SQRT, S_SQRTW, S_DIV, S_DIVW,
    S_NEXT, S_OUT
  } state_t;

  // what the shared units are working on
  typedef enum logic [3:0] {
    P_A, P_HB, P_C, P_DISC, P_POINT, P_LEN, P_DOT, P_ROOT1, P_ROOT2, P_NORM
  } phase_t;

  // input field split
  logic [3:0]         in_index;
  logic signed [31:0] in_o [3];
  logic signed [31:0] in_d [3];
  logic [47:0]        in_rs;
  logic [23:0]        in_alb;
  logic signed [31:0] in_tmin;
  logic signed [31:0] in_tmax;

  assign in_index = s_tdata[3:0];
  assign in_o[0]  = s_tdata[35:4];
  assign in_o[1]  = s_tdata[67:36];
  assign in_o[2]  = s_tdata[99:68];
  assign in_d[0]  = s_tdata[131:100];
  assign in_d[1]  = s_tdata[163:132];
  assign in_d[2]  = s_tdata[195:164];
  assign in_rs    = s_tdata[243:196];
  assign in_alb   = s_tdata[267:244];
  assign in_tmin  = s_tdata[299:268];
  assign in_tmax  = s_tdata[331:300];

  // configuration register
  logic [4:0] sphere_count;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {27'd0, sphere_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_count <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      sphere_count <= pwdata[4:0];
    end
  end

  // sequencer registers
  state_t             state;
  phase_t             phase;
  logic [1:0]         lane;
  logic [KW-1:0]      k;
  logic [KW-1:0]      k_inc;
  logic [KW-1:0]      n;
  logic               any;
  logic [IW-1:0]      best;
  logic signed [31:0] o [3];
  logic signed [31:0] d [3];
  logic signed [31:0] tmin;
  logic signed [31:0] tcur;
  logic signed [31:0] best_t;
  logic signed [31:0] bc [3];
  logic [23:0]        balb;
  logic signed [32:0] oc [3];
  logic [PROD_W-1:0]  sum;
  logic signed [63:0] a;
  logic signed [63:0] hb;
  logic signed [63:0] c;
  logic [63:0]        s;
  logic [63:0]        len;
  logic signed [31:0] p [3];
  logic signed [32:0] v [3];
  logic signed [17:0] nrm [3];
  logic               front;
  logic               div_neg;

  // sphere table, one read port registered
  entry_t             mem [MAX_SPHERES];
  entry_t             rd_q;
  logic signed [31:0] cen [3];

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready && s_tuser[0] == CMD_LOAD &&
        32'(in_index) < MAX_SPHERES) begin
      mem[IW'(in_index)] <= '{alb: in_alb, rs: in_rs, cz: in_o[2], cy: in_o[1],
                              cx: in_o[0]};
    end
    rd_q <= mem[k[IW-1:0]];
  end

  assign cen[0] = rd_q.cx;
  assign cen[1] = rd_q.cy;
  assign cen[2] = rd_q.cz;

  // shared multiplier
  logic               mul_start;
  logic signed [63:0] mul_a;
  logic signed [63:0] mul_b;
  logic               mul_done;
  logic [PROD_W-1:0]  mul_p;

  assign mul_start = (state == S_MUL);

  always_comb begin
    unique case (phase)
      P_A: begin
        mul_a = 64'(d[lane]);
        mul_b = 64'(d[lane]);
      end
      P_HB: begin
        mul_a = 64'(oc[lane]);
        mul_b = 64'(d[lane]);
      end
      P_C: begin
        mul_a = 64'(oc[lane]);
        mul_b = 64'(oc[lane]);
      end
      P_DISC: begin
        mul_a = lane[0] ? a : hb;
        mul_b = lane[0] ? c : hb;
      end
      P_POINT: begin
        mul_a = 64'(d[lane]);
        mul_b = 64'(best_t);
      end
      P_LEN: begin
        mul_a = 64'(v[lane]);
        mul_b = 64'(v[lane]);
      end
      P_DOT: begin
        mul_a = 64'(d[lane]);
        mul_b = 64'(nrm[lane]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  rsch_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  // shared square root
  logic                  sq_start;
  logic                  sq_done;
  logic [SQRT_OUT_W-1:0] sq_root;

  assign sq_start = (state == S_SQRT);

  rsch_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .x     (sum),
    .done  (sq_done),
    .root  (sq_root)
  );

  // shared divider; numerator magnitude scaled by 2^16
  logic               dv_start;
  logic signed [63:0] dv_sn;
  logic [63:0]        dv_mag;
  logic [DIV_D_W-1:0] dv_den;
  logic               dv_done;
  logic [DIV_N_W-1:0] dv_q;

  assign dv_start = (state == S_DIV);

  always_comb begin
    unique case (phase)
      P_ROOT1: dv_sn = -hb - $signed(s);
      P_ROOT2: dv_sn = -hb + $signed(s);
      P_NORM:  dv_sn = 64'(v[lane]);
      default: dv_sn = '0;
    endcase
  end

  assign dv_mag = dv_sn[63] ? 64'(-dv_sn) : 64'(dv_sn);
  assign dv_den = (phase == P_NORM) ? len : a;

  rsch_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   ({dv_mag, 16'd0}),
    .den   (dv_den),
    .done  (dv_done),
    .quo   (dv_q)
  );

  // result handling of the units
  logic [PROD_W-1:0]  sum_new;
  logic [PROD_W-1:0]  c_diff;
  logic [1:0]         lane_last;
  logic signed [47:0] dt;
  logic signed [49:0] pt_sum;
  logic signed [31:0] pt_sat;
  logic [40:0]        root_mag;
  logic signed [41:0] root_s;
  logic               in_win;
  logic [17:0]        q18;

  assign sum_new   = (phase == P_DISC && lane[0]) ? sum - mul_p : sum + mul_p;
  assign c_diff    = sum_new - {64'd0, rd_q.rs, 16'd0};
  assign lane_last = (phase == P_DISC) ? 2'd1 : 2'd2;
  assign k_inc     = k + 1'b1;

  // hit point: origin plus floor(dir * t / 2^16), clamped to 32 bits
  assign dt     = mul_p[63:16];
  assign pt_sum = 50'(o[lane]) + 50'(dt);
  always_comb begin
    if (pt_sum > 50'sd2147483647) begin
      pt_sat = 32'sh7fffffff;
    end else if (pt_sum < -50'sd2147483648) begin
      pt_sat = 32'sh80000000;
    end else begin
      pt_sat = pt_sum[31:0];
    end
  end

  // roots beyond the limit never land inside a 32-bit window
  assign root_mag = (dv_q > ROOT_LIMIT) ? ROOT_LIMIT[40:0] : dv_q[40:0];
  assign root_s   = div_neg ? -$signed({1'b0, root_mag}) : $signed({1'b0, root_mag});
  assign in_win   = (root_s >= 42'(tmin)) && (root_s <= 42'(tcur));
  assign q18      = dv_q[17:0];

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      any      <= 1'b0;
      phase    <= P_A;
      lane     <= '0;
      k        <= '0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid && s_tuser[0] == CMD_TRACE) begin
            for (int i = 0; i < 3; i++) begin
              o[i] <= in_o[i];
              d[i] <= in_d[i];
            end
            tmin  <= in_tmin;
            tcur  <= in_tmax;
            any   <= 1'b0;
            front <= 1'b0;
            k     <= '0;
            if (32'(sphere_count) > MAX_SPHERES) begin
              n <= KW'(MAX_SPHERES);
            end else begin
              n <= KW'(sphere_count);
            end
            if (sphere_count == 5'd0) begin
              state <= S_OUT;
            end else begin
              state <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          state <= S_OC;
        end
        S_OC: begin
          for (int i = 0; i < 3; i++) begin
            oc[i] <= 33'(o[i]) - 33'(cen[i]);
          end
          sum   <= '0;
          phase <= P_A;
          lane  <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_MULW;
        end
        S_MULW: begin
          if (mul_done) begin
            if (phase == P_POINT) begin
              p[lane] <= pt_sat;
              v[lane] <= 33'(pt_sat) - 33'(bc[lane]);
              if (lane == 2'd2) begin
                phase <= P_LEN;
                lane  <= '0;
                sum   <= '0;
              end else begin
                lane <= lane + 2'd1;
              end
              state <= S_MUL;
            end else if (lane != lane_last) begin
              sum   <= sum_new;
              lane  <= lane + 2'd1;
              state <= S_MUL;
            end else begin
              lane <= '0;
              unique case (phase)
                P_A: begin
                  a     <= sum_new[79:16];
                  sum   <= '0;
                  phase <= P_HB;
                  state <= S_MUL;
                end
                P_HB: begin
                  hb    <= sum_new[79:16];
                  sum   <= '0;
                  phase <= P_C;
                  state <= S_MUL;
                end
                P_C: begin
                  c   <= c_diff[79:16];
                  sum <= '0;
                  // a direction too short to register misses everything
                  if (a <= 64'sd0) begin
                    state <= S_NEXT;
                  end else begin
                    phase <= P_DISC;
                    state <= S_MUL;
                  end
                end
                P_DISC: begin
                  sum <= sum_new;
                  if (sum_new[PROD_W-1]) begin
                    state <= S_NEXT;
                  end else begin
                    state <= S_SQRT;
                  end
                end
                P_LEN: begin
                  sum   <= sum_new;
                  state <= S_SQRT;
                end
                default: begin
                  // dot product of direction and normal decides the face
                  front <= sum_new[PROD_W-1];
                  state <= S_OUT;
                end
              endcase
            end
          end
        end
        S_SQRT: begin
          state <= S_SQRTW;
        end
        S_SQRTW: begin
          if (sq_done) begin
            lane <= '0;
            if (phase == P_DISC) begin
              s     <= sq_root;
              phase <= P_ROOT1;
              state <= S_DIV;
            end else begin
              len <= sq_root;
              if (sq_root == '0) begin
                // degenerate normal: zero vector, back face
                for (int i = 0; i < 3; i++) begin
                  nrm[i] <= '0;
                end
                sum   <= '0;
                phase <= P_DOT;
                state <= S_MUL;
              end else begin
                phase <= P_NORM;
                state <= S_DIV;
              end
            end
          end
        end
        S_DIV: begin
          div_neg <= dv_sn[63];
          state   <= S_DIVW;
        end
        S_DIVW: begin
          if (dv_done) begin
            if (phase == P_NORM) begin
              nrm[lane] <= div_neg ? -$signed(q18) : $signed(q18);
              if (lane == 2'd2) begin
                lane  <= '0;
                sum   <= '0;
                phase <= P_DOT;
                state <= S_MUL;
              end else begin
                lane  <= lane + 2'd1;
                state <= S_DIV;
              end
            end else if (in_win) begin
              // accepted hit shrinks the window, later equal t wins
              any    <= 1'b1;
              best   <= k[IW-1:0];
              best_t <= root_s[31:0];
              tcur   <= root_s[31:0];
              for (int i = 0; i < 3; i++) begin
                bc[i] <= cen[i];
              end
              balb  <= rd_q.alb;
              state <= S_NEXT;
            end else if (phase == P_ROOT1) begin
              phase <= P_ROOT2;
              state <= S_DIV;
            end else begin
              state <= S_NEXT;
            end
          end
        end
        S_NEXT: begin
          k <= k_inc;
          if (k_inc == n) begin
            if (any) begin
              phase <= P_POINT;
              lane  <= '0;
              state <= S_MUL;
            end else begin
              state <= S_OUT;
            end
          end else begin
            state <= S_FETCH;
          end
        end
        default: begin
          // S_OUT: hand the result to the output register once it is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= any;
            if (any) begin
              m_tdata <= {5'd0, balb, front,
                          front ? nrm[2] : -nrm[2],
                          front ? nrm[1] : -nrm[1],
                          front ? nrm[0] : -nrm[0],
                          p[2], p[1], p[0], 4'(best), best_t};
            end else begin
              m_tdata <= '0;
            end
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stream testbench for ray_sphere_closest_hit
// loads sphere entries and traces rays through the input stream, predicts
// each closest hit in fixed point and compares every result field; random
// idling on both sides, one long result stall and several sphere counts
// ----------------------------------------------------------------------------
module tb_top;
  import rsch_pkg::*;

  typedef enum logic {CMD_LOAD = 1'b0, CMD_TRACE = 1'b1} cmd_e;
  localparam logic [2:0] REG_SPHERE_COUNT = 3'd0;
  localparam int NUM_ENTRIES = 16;
  localparam longint CYCLE_LIMIT = 6000000;
  localparam int LONG_STALL = 15000;
  localparam int UNIT = 65536;

  typedef logic signed [127:0] s128;

  typedef struct packed {
    logic        hit;
    logic [31:0] t;
    logic [3:0]  idx;
    logic [31:0] px, py, pz;
    logic [17:0] nx, ny, nz;
    logic        ff;
    logic [23:0] alb;
  } hit_rec_t;

  // ------------------------------------------------------------------------
  // closest-hit tracker: own copy of the sphere table and sphere_count,
  // predicts the result of every accepted trace
  // ------------------------------------------------------------------------
  class hit_tracker;
    longint      cx[NUM_ENTRIES], cy[NUM_ENTRIES], cz[NUM_ENTRIES];
    logic [47:0] rsq[NUM_ENTRIES];
    logic [23:0] alb[NUM_ENTRIES];
    logic [4:0]  count;
    hit_rec_t    hits_due[$];
    int          errors, loads, traces, hits, results;

    function new();
      count = 0;
    endfunction

    static function logic [63:0] isqrt(logic [127:0] x);
      logic [63:0]  r;
      logic [127:0] cnd;
      r = 0;
      for (int b = 62; b >= 0; b--) begin
        cnd = {64'd0, r | (64'd1 << b)};
        if (cnd * cnd <= x) r = r | (64'd1 << b);
      end
      return r;
    endfunction

    // |num| * 2^16 / den truncated, clamped at 2^40, sign of num
    static function longint root_div(s128 num, longint den);
      logic [127:0] m, q;
      m = num < 0 ? -num : num;
      q = (m << 16) / {64'd0, den};
      if (q > (128'd1 << 40)) q = 128'd1 << 40;
      return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    function hit_rec_t closest_hit(longint o[3], longint d[3], longint tmin, longint tmax);
      hit_rec_t r;
      s128      a32, hb32, c32, disc, l2;
      longint   oc[3], cen[3], p[3], v[3], nrm[3];
      longint   a, hb, c, s, root, tcur, best_t, dot, q;
      logic [63:0] len;
      int       n, best;
      bit       any;
      r = '0;
      tcur = tmax;
      any = 0;
      best = 0;
      best_t = 0;
      n = count > NUM_ENTRIES ? NUM_ENTRIES : count;
      for (int k = 0; k < n; k++) begin
        cen[0] = cx[k]; cen[1] = cy[k]; cen[2] = cz[k];
        a32 = 0; hb32 = 0; c32 = 0;
        for (int i = 0; i < 3; i++) begin
          oc[i] = o[i] - cen[i];
          a32 += s128'(d[i]) * s128'(d[i]);
          hb32 += s128'(oc[i]) * s128'(d[i]);
          c32 += s128'(oc[i]) * s128'(oc[i]);
        end
        c32 -= s128'({64'd0, rsq[k], 16'd0});
        a = longint'(a32 >>> 16);
        hb = longint'(hb32 >>> 16);
        c = longint'(c32 >>> 16);
        if (a <= 0) continue;
        disc = s128'(hb) * s128'(hb) - s128'(a) * s128'(c);
        if (disc < 0) continue;
        s = longint'(isqrt(disc));
        root = root_div(s128'(-hb) - s128'(s), a);
        if (root < tmin || root > tcur) begin
          root = root_div(s128'(-hb) + s128'(s), a);
          if (root < tmin || root > tcur) continue;
        end
        any = 1;
        best = k;
        best_t = root;
        tcur = root;
      end
      if (!any) return r;
      cen[0] = cx[best]; cen[1] = cy[best]; cen[2] = cz[best];
      l2 = 0;
      for (int i = 0; i < 3; i++) begin
        p[i] = o[i] + ((d[i] * best_t) >>> 16);
        if (p[i] > 64'sd2147483647) p[i] = 64'sd2147483647;
        if (p[i] < -64'sd2147483648) p[i] = -64'sd2147483648;
        v[i] = p[i] - cen[i];
        l2 += s128'(v[i]) * s128'(v[i]);
      end
      len = isqrt(l2);
      dot = 0;
      for (int i = 0; i < 3; i++) begin
        if (len == 0) begin
          nrm[i] = 0;
        end else begin
          q = longint'(((v[i] < 0 ? -v[i] : v[i]) << 16) / len);
          nrm[i] = v[i] < 0 ? -q : q;
        end
        dot += d[i] * nrm[i];
      end
      r.ff = dot < 0;
      // back face: flip the normal toward the ray
      if (!r.ff) for (int i = 0; i < 3; i++) nrm[i] = -nrm[i];
      r.hit = 1;
      r.t = best_t[31:0];
      r.idx = best[3:0];
      r.px = p[0][31:0]; r.py = p[1][31:0]; r.pz = p[2][31:0];
      r.nx = nrm[0][17:0]; r.ny = nrm[1][17:0]; r.nz = nrm[2][17:0];
      r.alb = alb[best];
      return r;
    endfunction

    function void note_request(logic cmd, logic [S_TDATA_W-1:0] td);
      longint o[3], d[3];
      int     e;
      o[0] = longint'(signed'(td[35:4]));
      o[1] = longint'(signed'(td[67:36]));
      o[2] = longint'(signed'(td[99:68]));
      d[0] = longint'(signed'(td[131:100]));
      d[1] = longint'(signed'(td[163:132]));
      d[2] = longint'(signed'(td[195:164]));
      if (cmd == CMD_LOAD) begin
        e = td[3:0];
        cx[e] = o[0]; cy[e] = o[1]; cz[e] = o[2];
        rsq[e] = td[243:196];
        alb[e] = td[267:244];
        loads++;
      end else begin
        hits_due.push_back(closest_hit(o, d, longint'(signed'(td[299:268])),
                                       longint'(signed'(td[331:300]))));
        traces++;
      end
    endfunction

    function void check_hit(logic hit, logic [M_TDATA_W-1:0] td);
      hit_rec_t x, g;
      results++;
      if (hits_due.size() == 0) begin
        $error("result with no trace outstanding");
        errors++;
        return;
      end
      x = hits_due.pop_front();
      g.hit = hit;
      g.t = td[31:0];     g.idx = td[35:32];
      g.px = td[67:36];   g.py = td[99:68];   g.pz = td[131:100];
      g.nx = td[149:132]; g.ny = td[167:150]; g.nz = td[185:168];
      g.ff = td[186];     g.alb = td[210:187];
      if (g.hit) hits++;
      if (g.hit != x.hit) begin $error("hit exp %0d got %0d", x.hit, g.hit); errors++; end
      if (g.t != x.t) begin $error("hit_t exp %h got %h", x.t, g.t); errors++; end
      if (g.idx != x.idx) begin $error("hit_index exp %0d got %0d", x.idx, g.idx); errors++; end
      if (g.px != x.px) begin $error("point_x exp %h got %h", x.px, g.px); errors++; end
      if (g.py != x.py) begin $error("point_y exp %h got %h", x.py, g.py); errors++; end
      if (g.pz != x.pz) begin $error("point_z exp %h got %h", x.pz, g.pz); errors++; end
      if (g.nx != x.nx) begin $error("normal_x exp %h got %h", x.nx, g.nx); errors++; end
      if (g.ny != x.ny) begin $error("normal_y exp %h got %h", x.ny, g.ny); errors++; end
      if (g.nz != x.nz) begin $error("normal_z exp %h got %h", x.nz, g.nz); errors++; end
      if (g.ff != x.ff) begin $error("front_face exp %0d got %0d", x.ff, g.ff); errors++; end
      if (g.alb != x.alb) begin $error("hit_albedo exp %h got %h", x.alb, g.alb); errors++; end
    endfunction
  endclass

  // ------------------------------------------------------------------------
  // clock, reset and block
  // ------------------------------------------------------------------------
  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;  // entry_index, origin_xyz, dir_xyz, radius_squared,
                                       // albedo_rgb, t_min, t_max
  logic [0:0] s_tuser = '0;            // cmd
  logic m_tvalid;
  logic m_tready = 0;
  logic [M_TDATA_W-1:0] m_tdata;       // hit_t, hit_index, point_xyz, normal_xyz,
                                       // front_face, hit_albedo
  logic [0:0] m_tuser;                 // hit
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  hit_tracker tracker = new();
  longint cycles = 0;
  bit calm = 0;        // no idling on either side while set
  int configs = 0;

  always #1 clk = ~clk;

  ray_sphere_closest_hit dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // result side: random stalls, one long hold-off once results flow
  // ------------------------------------------------------------------------
  initial begin
    int  stall_left;
    bit  long_done;
    stall_left = 0;
    long_done = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) tracker.check_hit(m_tuser[0], m_tdata);
      if (!long_done && tracker.results == 30) begin
        // hold off long enough for the block to back up onto its input
        long_done = 1;
        stall_left = LONG_STALL;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 0;
      end else begin
        m_tready <= 1;
        if (!calm && $urandom_range(0, 9) == 0)
          stall_left = $urandom_range(0, 19) == 0 ? $urandom_range(20, 400)
                                                  : $urandom_range(1, 4);
      end
    end
  end

  // ------------------------------------------------------------------------
  // input side
  // ------------------------------------------------------------------------
  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // valid stays high into the next transaction when no gap follows
  task automatic send(cmd_e cmd, logic [S_TDATA_W-1:0] td);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= cmd;
    s_tdata <= td;
    do @(posedge clk); while (!s_tready);
    tracker.note_request(cmd, td);
  endtask

  task automatic load(logic [3:0] e, logic [31:0] x, y, z, logic [47:0] rs, logic [23:0] al);
    send(CMD_LOAD, {4'd0, 32'($urandom), 32'($urandom), al, rs, 32'($urandom),
                    32'($urandom), 32'($urandom), z, y, x, e});
  endtask

  task automatic trace(logic [31:0] ox, oy, oz, dx, dy, dz, tmn, tmx);
    send(CMD_TRACE, {4'd0, tmx, tmn, 24'($urandom), 48'({$urandom, $urandom}),
                     dz, dy, dx, oz, oy, ox, 4'($urandom)});
  endtask

  // idle point: everything back, then a margin for a trailing load
  task automatic drain();
    s_tvalid <= 0;
    while (tracker.hits_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_count(logic [4:0] n);
    psel <= 1;
    pwrite <= 1;
    paddr <= REG_SPHERE_COUNT;
    pwdata <= 32'(n);
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    tracker.count = n;
    configs++;
  endtask

  function automatic int srand(int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  task automatic random_load();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0)  // full-range noise
      load(4'($urandom), $urandom, $urandom, $urandom, 48'({$urandom, $urandom}), 24'($urandom));
    else
      load(4'($urandom), srand(16 * UNIT), srand(16 * UNIT), srand(16 * UNIT),
           r == 1 ? 48'd0 : 48'($urandom_range(UNIT / 8, 9 * UNIT)), 24'($urandom));
  endtask

  // mostly rays aimed near a scanned sphere, some from its center, some noise
  task automatic random_trace();
    int k, n, r, sh, ox, oy, oz, dx, dy, dz, tmn, tmx;
    n = tracker.count > NUM_ENTRIES ? NUM_ENTRIES : tracker.count;
    k = n == 0 ? $urandom_range(0, 15) : $urandom_range(0, n - 1);
    r = $urandom_range(0, 19);
    if (r == 0) begin
      trace($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      return;
    end
    if (r < 3) begin
      ox = int'(tracker.cx[k]); oy = int'(tracker.cy[k]); oz = int'(tracker.cz[k]);
    end else begin
      ox = srand(20 * UNIT); oy = srand(20 * UNIT); oz = srand(20 * UNIT);
    end
    dx = int'(tracker.cx[k]) + srand(2 * UNIT) - ox;
    dy = int'(tracker.cy[k]) + srand(2 * UNIT) - oy;
    dz = int'(tracker.cz[k]) + srand(2 * UNIT) - oz;
    sh = $urandom_range(0, 4);
    if (sh < 3) begin dx >>>= sh; dy >>>= sh; dz >>>= sh; end
    tmn = $urandom_range(0, 3) == 0 ? srand(2 * UNIT) : 0;
    tmx = $urandom_range(0, 3) == 0 ? int'($urandom_range(0, 4 * UNIT)) : 32'h7fffffff;
    trace(ox, oy, oz, dx, dy, dz, tmn, tmx);
  endtask

  // ------------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------------
  initial begin
    logic [4:0] counts[10];
    int         sizes[10];
    counts = '{5'd1, 5'd0, 5'd4, 5'd16, 5'd2, 5'd31, 5'd7, 5'd17, 5'd3, 5'd12};
    sizes  = '{70, 40, 70, 25, 70, 25, 70, 25, 70, 25};
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: fill the whole table first so no scan reads an unwritten entry
    load(4'd0, 32'h7fffffff, 32'h80000000, 32'h0, 48'd65536, 24'h000000);
    load(4'd1, 32'h80000000, 32'h7fffffff, 32'hffffffff, 48'd1, 24'h123456);
    load(4'd2, 2 << 18, 50 * UNIT, 0, UNIT, 24'h00ff00);
    // identical spheres: equal t must go to the later entry
    load(4'd3, 0, 0, 10 * UNIT, UNIT, 24'haa0000);
    load(4'd4, 0, 0, 10 * UNIT, UNIT, 24'h00aa00);
    // zero radius on the x axis: hit point equals the center
    load(4'd5, 200 * UNIT, 0, 0, 48'd0, 24'h0000aa);
    for (int e = 6; e < 15; e++)
      load(e, e << 18, 50 * UNIT, -(e << 16), UNIT, 24'(e * 24'h111111));
    load(4'd15, -(30 * UNIT), -(30 * UNIT), -(30 * UNIT), 48'hffffffffffff, 24'hffffff);
    drain();
    set_count(5'd16);
    trace(0, 0, 0, 0, 0, 0, 0, 32'h7fffffff);               // zero direction
    trace(0, 0, 0, 1, 0, 0, 0, 32'h7fffffff);               // direction too short
    trace(0, 0, 0, 0, 0, UNIT, 5 * UNIT, UNIT);             // empty window
    trace(0, 0, 0, 0, 0, UNIT, 0, 32'h7fffffff);            // tie between 3 and 4
    trace(0, 0, 10 * UNIT, UNIT, UNIT / 2, 0, 0, 32'h7fffffff);  // from inside
    trace(198 * UNIT, 0, 0, UNIT, 0, 0, 0, 32'h7fffffff);   // degenerate normal
    trace(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
          32'h7fffffff, 32'h80000000, 32'h7fffffff);        // extremes
    drain();

    // random phases, each under its own sphere count
    for (int ph = 0; ph < 10; ph++) begin
      calm = (ph % 3 == 2);
      set_count(counts[ph]);
      for (int i = 0; i < sizes[ph]; i++) begin
        if ($urandom_range(0, 99) < 35) random_load();
        else random_trace();
        // one pause mid-phase until every result is back
        if (ph == 4 && i == sizes[ph] / 2) drain();
      end
      drain();
    end
    calm = 0;
    repeat (200) @(posedge clk);

    $display("covered %0d loads, %0d traces (%0d hits) under %0d sphere counts",
             tracker.loads, tracker.traces, tracker.hits, configs);
    if (tracker.errors == 0 && tracker.hits_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
